[sv/hdflc_pkg.sv]
`default_nettype none

package hdflc_pkg;

  // Default depth of the payload store
  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [7:0] START_CHAR_RST    = 8'h23;
  localparam logic [7:0] END_CHAR_RST      = 8'h24;
  localparam logic [6:0] PAYLOAD_LIMIT_RST = 7'd34;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;  // input word accepted this cycle
    logic rd_en;      // read the payload store
    logic idx_adv;    // step to the next payload byte of the burst
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic end_hit;     // byte closes an open frame
    logic len_zero;    // stored frame is empty
    logic burst_last;  // current result is the last of the burst
  } ctrl_stat_t;

endpackage

`default_nettype wire

[sv/hdflc_ram.sv]
`default_nettype none

module hdflc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/hdflc_ctrl.sv]
`default_nettype none

module hdflc_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output hdflc_pkg::ctrl_cmd_t        cmd_o,
  input  wire hdflc_pkg::ctrl_stat_t  stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    s_tready_o    = 1'b0;
    m_tvalid_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o      = 1'b1;
        cmd_o.take_byte = s_tvalid_i;
        if (s_tvalid_i && stat_i.end_hit) begin
          // empty frame skips the store read
          state_d = stat_i.len_zero ? ST_SHOW : ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SHOW;
      end
      ST_SHOW: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          if (stat_i.burst_last) begin
            state_d = ST_IDLE;
          end else begin
            // prefetch the next byte while this word leaves
            cmd_o.rd_en   = 1'b1;
            cmd_o.idx_adv = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/hdflc_dpath.sv]
`default_nettype none

module hdflc_dpath #(
  parameter int unsigned MAX_PAYLOAD = hdflc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [hdflc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hdflc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [7:0]                       rx_byte_i,
  input  wire hdflc_pkg::ctrl_cmd_t             cmd_i,
  output hdflc_pkg::ctrl_stat_t                 stat_o,
  output logic      [7:0]                       payload_byte_o,
  output logic                                  byte_valid_o,
  output logic      [5:0]                       byte_index_o,
  output logic      [6:0]                       frame_length_o,
  output logic      [6:0]                       lower_count_o,
  output logic      [6:0]                       upper_count_o,
  output logic                                  last_o
);

  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = $clog2(MAX_PAYLOAD);
  localparam int unsigned EW = (LW > 7) ? LW : 7;

  logic [7:0]    start_char_q, end_char_q;
  logic [6:0]    limit_q;
  logic          open_q, open_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] low_q, low_d;
  logic [LW-1:0] up_q, up_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] idx_inc;

  logic          is_start, is_end, is_lower, is_upper, full, store_en;
  logic [EW-1:0] len_ext, low_ext, up_ext, idx_ext, lim_ext, max_ext;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= hdflc_pkg::START_CHAR_RST;
      end_char_q   <= hdflc_pkg::END_CHAR_RST;
      limit_q      <= hdflc_pkg::PAYLOAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdflc_pkg::REG_START_CHAR:    start_char_q <= cfg_data_i;
        hdflc_pkg::REG_END_CHAR:      end_char_q   <= cfg_data_i;
        hdflc_pkg::REG_PAYLOAD_LIMIT: limit_q      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign is_start = (rx_byte_i == start_char_q);
  assign is_end   = (rx_byte_i == end_char_q);
  assign is_lower = rx_byte_i inside {[hdflc_pkg::CH_LOWER_A:hdflc_pkg::CH_LOWER_Z]};
  assign is_upper = rx_byte_i inside {[hdflc_pkg::CH_UPPER_A:hdflc_pkg::CH_UPPER_Z]};

  assign len_ext = EW'(len_q);
  assign low_ext = EW'(low_q);
  assign up_ext  = EW'(up_q);
  assign idx_ext = EW'(idx_q);
  assign lim_ext = EW'(limit_q);
  assign max_ext = EW'(MAX_PAYLOAD);

  // limit above the store depth acts as the depth
  assign full     = (len_ext >= lim_ext) || (len_ext >= max_ext);
  assign store_en = cmd_i.take_byte && open_q && !is_start && !is_end && !full;
  assign idx_inc  = idx_q + LW'(1);

  always_comb begin
    open_d = open_q;
    len_d  = len_q;
    low_d  = low_q;
    up_d   = up_q;
    idx_d  = idx_q;
    if (cmd_i.take_byte) begin
      if (is_start) begin
        open_d = 1'b1;
        len_d  = '0;
        low_d  = '0;
        up_d   = '0;
      end else if (open_q) begin
        if (is_end) begin
          open_d = 1'b0;
          idx_d  = '0;
        end else if (full) begin
          // overlong frame: drop it silently
          open_d = 1'b0;
          len_d  = '0;
          low_d  = '0;
          up_d   = '0;
        end else begin
          len_d = len_q + LW'(1);
          if (is_lower) begin
            low_d = low_q + LW'(1);
          end else if (is_upper) begin
            up_d = up_q + LW'(1);
          end
        end
      end
    end else if (cmd_i.idx_adv) begin
      idx_d = idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      len_q  <= '0;
      low_q  <= '0;
      up_q   <= '0;
      idx_q  <= '0;
    end else begin
      open_q <= open_d;
      len_q  <= len_d;
      low_q  <= low_d;
      up_q   <= up_d;
      idx_q  <= idx_d;
    end
  end

  assign raddr = cmd_i.idx_adv ? idx_inc[AW-1:0] : idx_q[AW-1:0];

  hdflc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.end_hit    = open_q && !is_start && is_end;
  assign stat_o.len_zero   = (len_q == '0);
  assign stat_o.burst_last = stat_o.len_zero || (idx_inc == len_q);

  assign payload_byte_o = stat_o.len_zero ? 8'h00 : ram_rdata;
  assign byte_valid_o   = !stat_o.len_zero;
  assign byte_index_o   = idx_ext[5:0];
  assign frame_length_o = len_ext[6:0];
  assign lower_count_o  = low_ext[6:0];
  assign upper_count_o  = up_ext[6:0];
  assign last_o         = stat_o.burst_last;

endmodule

`default_nettype wire

[sv/hash_dollar_frame_letter_counter.sv]
// Frame letter counter: scans a received byte stream for frames made of a start
// byte, payload bytes and an end byte (by default '#' and '$', set via the
// configuration port). Payload bytes are kept in a store of MAX_PAYLOAD bytes and
// lower- and upper-case letters are counted; a frame that grows past
// payload_limit is dropped without output. The end byte releases the frame as a
// burst of words, one payload byte each with its index, the frame length, both
// counts and tlast on the final word; an empty frame gives a single word with
// tuser low. Each received byte is taken while no burst is pending. A burst
// starts with the registered read of the payload store, skipped for an empty
// frame, then gives one word per cycle while the sink does not stall, since the
// next store read is issued while the current word is taken. No input is taken
// while a burst is out. There is no clearing pass after reset; the store is only
// read where the current frame wrote it.
`default_nettype none

module hash_dollar_frame_letter_counter #(
  parameter int unsigned MAX_PAYLOAD = hdflc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [hdflc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [hdflc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [7:0] rx_byte
  input  wire logic [hdflc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] payload_byte, [13:8] byte_index, [20:14] frame_length,
  // [27:21] lower_count, [34:28] upper_count, [39:35] zero
  output logic      [hdflc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] byte_valid
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tlast
);

  hdflc_pkg::ctrl_cmd_t  cmd;
  hdflc_pkg::ctrl_stat_t stat;

  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic [6:0] frame_length, lower_count, upper_count;

  hdflc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  hdflc_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (s_axis_tdata[7:0]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .payload_byte_o (payload_byte),
    .byte_valid_o   (m_axis_tuser),
    .byte_index_o   (byte_index),
    .frame_length_o (frame_length),
    .lower_count_o  (lower_count),
    .upper_count_o  (upper_count),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {{hdflc_pkg::OUT_PAD_W{1'b0}}, upper_count, lower_count,
                         frame_length, byte_index, payload_byte};

  // input side is closed while a burst is out
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken during a burst");

  // an empty frame is a single word
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("empty frame word without tlast");

  // a taken word that is not last is followed at once by the next word
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("burst broke off before tlast");

  // an accepted closing byte of an empty frame goes straight to its word, with no store read
  a_end_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take_byte && stat.end_hit) |=> (m_axis_tvalid || $past(!stat.len_zero)))
    else $error("empty frame did not show its word");

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYC   = 300;
  localparam int STALL_MAX  = 3000;
  localparam int ERR_PRINTS = 30;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [5:0] byte_index;
    logic [6:0] frame_length;
    logic [6:0] lower_count;
    logic [6:0] upper_count;
    logic       last;
  } burst_word_t;

  typedef struct {
    logic [7:0]  rx;
    bit          pinned;
    burst_word_t word;
  } script_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [hdflc_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [hdflc_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [hdflc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // [7:0] payload_byte, [13:8] byte_index, [20:14] frame_length,
  // [27:21] lower_count, [34:28] upper_count, [39:35] zero
  logic [hdflc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                              m_axis_tuser;        // [0] byte_valid
  logic                              m_axis_tlast;

  hash_dollar_frame_letter_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Frame tracker state, mirrored from the accepted words and register writes
  logic [7:0]  mon_start = hdflc_pkg::START_CHAR_RST;
  logic [7:0]  mon_end   = hdflc_pkg::END_CHAR_RST;
  logic [6:0]  mon_lim   = hdflc_pkg::PAYLOAD_LIMIT_RST;
  bit          frm_open  = 1'b0;
  int          frm_len   = 0;
  int          lower_n   = 0;
  int          upper_n   = 0;
  logic [7:0]  frm_bytes [64];
  burst_word_t pending_words [$];
  burst_word_t head;
  int          words_before;

  // Stimulus side copies of the settings
  logic [7:0] drv_start = hdflc_pkg::START_CHAR_RST;
  logic [7:0] drv_end   = hdflc_pkg::END_CHAR_RST;
  int         drv_lim   = hdflc_pkg::PAYLOAD_LIMIT_RST;
  logic [7:0] same_char;

  bit          pin_valid = 1'b0;
  burst_word_t pin_word  = '0;
  int          tx_idle_pct = 10;
  int          rx_idle_pct = 74;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          stall_cycles = 0;

  int errors   = 0;
  int n_sent   = 0;
  int n_frames = 0;
  int n_drops  = 0;
  int n_words  = 0;

  // Directed words; typed results only where they are obvious
  script_row_t script [0:22] = '{
    '{8'h24, 1'b0, '0},   // end byte with no frame open
    '{8'hFF, 1'b0, '0},   // noise before any start
    '{8'h23, 1'b0, '0},
    '{8'h24, 1'b1, '{8'h00, 1'b0, 6'd0, 7'd0, 7'd0, 7'd0, 1'b1}},
    '{8'h23, 1'b0, '0},
    '{8'h61, 1'b0, '0},
    '{8'h24, 1'b1, '{8'h61, 1'b1, 6'd0, 7'd1, 7'd1, 7'd0, 1'b1}},
    '{8'h23, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h24, 1'b1, '{8'h5A, 1'b1, 6'd0, 7'd1, 7'd0, 7'd1, 1'b1}},
    '{8'h23, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'h7A, 1'b0, '0},
    '{8'h40, 1'b0, '0},   // letter range edges
    '{8'h5B, 1'b0, '0},
    '{8'h60, 1'b0, '0},
    '{8'h7B, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h23, 1'b0, '0},   // restart inside a frame
    '{8'h30, 1'b0, '0},
    '{8'h24, 1'b1, '{8'h30, 1'b1, 6'd0, 7'd1, 7'd0, 7'd0, 1'b1}},
    '{8'h80, 1'b0, '0}
  };

  task automatic track_byte(input logic [7:0] b);
    int          lim;
    burst_word_t w;
    lim = (mon_lim > 64) ? 64 : int'(mon_lim);
    if (b == mon_start) begin
      frm_open = 1'b1;
      frm_len  = 0;
      lower_n  = 0;
      upper_n  = 0;
    end else if (frm_open) begin
      if (b == mon_end) begin
        frm_open = 1'b0;
        n_frames++;
        if (frm_len == 0) begin
          w      = '0;
          w.last = 1'b1;
          pending_words.push_back(w);
        end else begin
          for (int k = 0; k < frm_len; k++) begin
            w.payload_byte = frm_bytes[k];
            w.byte_valid   = 1'b1;
            w.byte_index   = 6'(k);
            w.frame_length = 7'(frm_len);
            w.lower_count  = 7'(lower_n);
            w.upper_count  = 7'(upper_n);
            w.last         = (k == frm_len - 1);
            pending_words.push_back(w);
          end
        end
      end else if (frm_len >= lim) begin
        // overlong: drop the frame and this byte
        frm_open = 1'b0;
        frm_len  = 0;
        lower_n  = 0;
        upper_n  = 0;
        n_drops++;
      end else begin
        if (b >= hdflc_pkg::CH_LOWER_A && b <= hdflc_pkg::CH_LOWER_Z) lower_n++;
        else if (b >= hdflc_pkg::CH_UPPER_A && b <= hdflc_pkg::CH_UPPER_Z) upper_n++;
        frm_bytes[frm_len] = b;
        frm_len++;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= ERR_PRINTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_words++;
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= ERR_PRINTS)
            $display("%0t: expected no word, got tdata %h tuser %b tlast %b", $time,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          head = pending_words.pop_front();
          check_field("payload_byte", head.payload_byte, m_axis_tdata[7:0]);
          check_field("byte_index", head.byte_index, m_axis_tdata[13:8]);
          check_field("frame_length", head.frame_length, m_axis_tdata[20:14]);
          check_field("lower_count", head.lower_count, m_axis_tdata[27:21]);
          check_field("upper_count", head.upper_count, m_axis_tdata[34:28]);
          check_field("tdata pad", 0, m_axis_tdata[39:35]);
          check_field("byte_valid", head.byte_valid, m_axis_tuser);
          check_field("last", head.last, m_axis_tlast);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hdflc_pkg::REG_START_CHAR:    mon_start = cfg_data_i;
          hdflc_pkg::REG_END_CHAR:      mon_end   = cfg_data_i;
          hdflc_pkg::REG_PAYLOAD_LIMIT: mon_lim   = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_before = pending_words.size();
        track_byte(s_axis_tdata);
        // typed result replaces the predicted one for this word
        if (pin_valid) begin
          while (pending_words.size() > words_before) void'(pending_words.pop_back());
          pending_words.push_back(pin_word);
        end
      end
    end
  end

  // Sink: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt < HOLD_CYC) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_MAX) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", STALL_MAX);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic push_byte(input logic [7:0] rx, input bit pinned, input burst_word_t word);
    s_axis_tdata  <= rx;
    s_axis_tvalid <= 1'b1;
    pin_valid     <= pinned;
    pin_word      <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    int         k;
    do begin
      k = $urandom_range(0, 9);
      if (k < 4) b = 8'(hdflc_pkg::CH_LOWER_A + $urandom_range(0, 25));
      else if (k < 7) b = 8'(hdflc_pkg::CH_UPPER_A + $urandom_range(0, 25));
      else b = 8'($urandom_range(0, 255));
    end while (b == drv_start || b == drv_end);
    return b;
  endfunction

  task automatic send_frame(input int len, input bit close);
    push_byte(drv_start, 1'b0, '0);
    repeat (len) push_byte(pick_payload(), 1'b0, '0);
    if (close) push_byte(drv_end, 1'b0, '0);
  endtask

  // Mostly well-formed frames; some noise, unclosed and overlong frames
  task automatic run_frames(input int budget);
    int used;
    int len;
    int pick;
    bit close;
    used = 0;
    while (used < budget) begin
      pick  = $urandom_range(0, 99);
      close = 1'b1;
      if (pick < 8) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        used++;
      end else begin
        if (pick < 16 && drv_lim <= 8) len = drv_lim + 1;
        else if (pick < 24 && drv_lim <= 8) len = drv_lim;
        else if (pick < 32) begin
          len   = $urandom_range(0, 4);
          close = 1'b0;
        end else len = $urandom_range(0, 6);
        send_frame(len, close);
        used += len + 2;
      end
    end
  endtask

  // Drain outstanding words, then give the block time to go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] s, input logic [7:0] e, input logic [7:0] l);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hdflc_pkg::REG_START_CHAR;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_idx_i  <= hdflc_pkg::REG_END_CHAR;
    cfg_data_i <= e;
    @(posedge clk_i);
    cfg_idx_i  <= hdflc_pkg::REG_PAYLOAD_LIMIT;
    cfg_data_i <= l;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    drv_start = s;
    drv_end   = e;
    drv_lim   = (l[6:0] > 64) ? 64 : int'(l[6:0]);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) push_byte(script[i].rx, script[i].pinned, script[i].word);

    settle();
    set_regs(8'h23, 8'h24, 8'd5);
    run_frames(5);

    settle();
    set_regs(8'h00, 8'hFF, 8'd1);
    run_frames(4);

    // swap idling: sender slow, sink mostly ready
    settle();
    tx_idle_pct = 74;
    rx_idle_pct <= 10;
    set_regs(8'hFF, 8'h00, 8'd64);
    send_frame(64, 1'b1);
    run_frames(2);

    settle();
    set_regs(8'h41, 8'h42, 8'd0);
    run_frames(3);

    // start and end share one byte; limit above the store depth
    settle();
    same_char = 8'($urandom_range(0, 255));
    set_regs(same_char, same_char, 8'hFF);
    run_frames(3);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    set_regs(8'h23, 8'h24, 8'd34);
    run_frames(2);

    // hold the sink off while words keep coming
    hold_req <= 1'b1;
    send_frame(3, 1'b1);
    run_frames(4);

    settle();
    repeat (12) @(posedge clk_i);
    $display("sent %0d input words: %0d frames closed, %0d dropped as overlong",
             n_sent, n_frames, n_drops);
    $display("checked %0d output words across 7 register settings and a %0d-cycle hold-off",
             n_words, HOLD_CYC);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
